// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the terminal screen engine.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define TTS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
	else $error("invariant violated");

// consequent holds in the same cycle as the antecedent
`define TTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("implication violated");

`endif

// File: src/tts_pkg.sv
// ---------------------------------------------------------------------------
// tts_pkg
// Types, constants and helpers of the text terminal screen engine.
// ---------------------------------------------------------------------------
`default_nettype none
package tts_pkg;

	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 128;
	localparam int HIST_LINES = 256;
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int HIST_W     = $clog2(HIST_LINES);
	localparam int SCR_DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int HIST_DEPTH = HIST_LINES * MAX_COLS;

	localparam int ACTION_W   = 2;
	localparam int BYTE_W     = 8;
	localparam int VROW_W     = 6;
	localparam int VCOL_W     = 7;
	localparam int DELTA_W    = 10;
	localparam int CCOL_W     = 8;
	localparam int VIEW_W     = 9;
	localparam int RROWS_W    = 7;
	localparam int RCOLS_W    = 8;
	localparam int PARAM_W    = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	localparam logic [ACTION_W-1:0] ACT_BYTE   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_SCROLL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 4'd1;

	localparam logic [7:0] CH_BLANK  = 8'h20;
	localparam logic [7:0] CH_ESC    = 8'h1b;
	localparam logic [7:0] CH_BEL    = 8'h07;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_DEL    = 8'h7f;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] FIN_H     = 8'h48;
	localparam logic [7:0] FIN_F     = 8'h66;
	localparam logic [7:0] FIN_A     = 8'h41;
	localparam logic [7:0] FIN_B     = 8'h42;
	localparam logic [7:0] FIN_C     = 8'h43;
	localparam logic [7:0] FIN_D     = 8'h44;
	localparam logic [7:0] FIN_J     = 8'h4a;
	localparam logic [7:0] FIN_K     = 8'h4b;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_PRINT,
		CMD_LF,
		CMD_CR,
		CMD_BS,
		CMD_TAB,
		CMD_CSI,
		CMD_READ,
		CMD_SCROLL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                  kind;
		logic [BYTE_W-1:0]          ch;
		logic [PARAM_W-1:0]         p1;
		logic [PARAM_W-1:0]         p2;
		logic [VROW_W-1:0]          vrow;
		logic [VCOL_W-1:0]          vcol;
		logic signed [DELTA_W-1:0]  delta;
	} cmd_t;

	function automatic logic [RROWS_W-1:0] eff_rows(input logic [RROWS_W-1:0] raw);
		logic [RROWS_W-1:0] r;
		r = raw;
		if (raw == '0) r = RROWS_W'(1);
		else if (raw > RROWS_W'(MAX_ROWS)) r = RROWS_W'(MAX_ROWS);
		return r;
	endfunction

	function automatic logic [RCOLS_W-1:0] eff_cols(input logic [RCOLS_W-1:0] raw);
		logic [RCOLS_W-1:0] c;
		c = raw;
		if (raw == '0) c = RCOLS_W'(1);
		else if (raw > RCOLS_W'(MAX_COLS)) c = RCOLS_W'(MAX_COLS);
		return c;
	endfunction

endpackage
`default_nettype wire

// File: src/tts_if.sv
// ---------------------------------------------------------------------------
// tts_if
// Channel interfaces: input items, result items and register writes.
// ---------------------------------------------------------------------------
`default_nettype none
interface tts_item_if import tts_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [ACTION_W-1:0]        action;
	logic [BYTE_W-1:0]          data_byte;
	logic [VROW_W-1:0]          view_row;
	logic [VCOL_W-1:0]          view_col;
	logic signed [DELTA_W-1:0]  scroll_delta;

	modport source (output valid, action, data_byte, view_row, view_col, scroll_delta,
		input ready);
	modport sink (input valid, action, data_byte, view_row, view_col, scroll_delta,
		output ready);
endinterface

interface tts_result_if import tts_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   cell_char;
	logic [ROW_W-1:0]    cursor_row;
	logic [CCOL_W-1:0]   cursor_col;
	logic [VIEW_W-1:0]   view_back;
	logic [VIEW_W-1:0]   history_lines_held;
	logic                view_changed;

	modport source (output valid, cell_char, cursor_row, cursor_col, view_back,
		history_lines_held, view_changed, input ready);
	modport sink (input valid, cell_char, cursor_row, cursor_col, view_back,
		history_lines_held, view_changed, output ready);
endinterface

interface tts_cfg_if import tts_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/tts_ram.sv
// ---------------------------------------------------------------------------
// tts_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module tts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [$clog2(DEPTH)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]          wdata,
	input  wire logic [$clog2(DEPTH)-1:0]  raddr,
	output logic      [WIDTH-1:0]          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: src/tts_front.sv
// ---------------------------------------------------------------------------
// tts_front
// Accepts input words, runs the escape parser and classifies each word
// into one command for the back end.
// ---------------------------------------------------------------------------
`default_nettype none
module tts_front import tts_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tts_item_if.sink   item,
	output logic       push,
	output cmd_t       push_cmd,
	input  wire logic  full
);
	typedef enum logic [2:0] {
		M_GROUND,
		M_ESC,
		M_CSI,
		M_OSC,
		M_OSC_ESC
	} mode_t;

	mode_t               mode_q, mode_d;
	logic [PARAM_W-1:0]  p1_q, p1_d, p2_q, p2_d;
	logic [2:0]          slot_q, slot_d;
	logic [PARAM_W-1:0]  p_sel;
	logic [19:0]         acc;
	logic [PARAM_W-1:0]  acc_sat;
	logic [BYTE_W-1:0]   c;

	assign item.ready = !full;
	assign push       = item.valid && !full;
	assign c          = item.data_byte;

	always_comb begin
		p_sel   = (slot_q == 3'd0) ? p1_q : p2_q;
		acc     = 20'(p_sel) * 20'd10 + 20'(c - CH_0);
		acc_sat = (acc > 20'hffff) ? 16'hffff : acc[PARAM_W-1:0];
	end

	always_comb begin
		mode_d         = mode_q;
		p1_d           = p1_q;
		p2_d           = p2_q;
		slot_d         = slot_q;
		push_cmd.kind  = CMD_NOP;
		push_cmd.ch    = c;
		push_cmd.p1    = p1_q;
		push_cmd.p2    = p2_q;
		push_cmd.vrow  = item.view_row;
		push_cmd.vcol  = item.view_col;
		push_cmd.delta = item.scroll_delta;
		unique case (item.action)
			ACT_BYTE: begin
				unique case (mode_q)
					M_ESC: begin
						if (c == CH_LBRACK) begin
							mode_d = M_CSI;
							p1_d   = '0;
							p2_d   = '0;
							slot_d = '0;
						end else if (c == CH_RBRACK) begin
							mode_d = M_OSC;
						end else begin
							mode_d = M_GROUND;
						end
					end
					M_CSI: begin
						if (c >= CH_0 && c <= CH_9) begin
							if (slot_q == 3'd0) p1_d = acc_sat;
							else if (slot_q == 3'd1) p2_d = acc_sat;
						end else if (c == CH_SEMI) begin
							if (slot_q != 3'd7) slot_d = slot_q + 3'd1;
						end else begin
							mode_d        = M_GROUND;
							push_cmd.kind = CMD_CSI;
						end
					end
					M_OSC: begin
						if (c == CH_BEL) mode_d = M_GROUND;
						else if (c == CH_ESC) mode_d = M_OSC_ESC;
					end
					M_OSC_ESC: begin
						if (c == CH_BSLASH || c == CH_BEL) mode_d = M_GROUND;
						else if (c != CH_ESC) mode_d = M_OSC;
					end
					default: begin
						priority if (c == CH_ESC) mode_d = M_ESC;
						else if (c == CH_LF) push_cmd.kind = CMD_LF;
						else if (c == CH_CR) push_cmd.kind = CMD_CR;
						else if (c == CH_BS || c == CH_DEL) push_cmd.kind = CMD_BS;
						else if (c == CH_TAB) push_cmd.kind = CMD_TAB;
						else if (c >= CH_BLANK) push_cmd.kind = CMD_PRINT;
						else push_cmd.kind = CMD_NOP;
					end
				endcase
			end
			ACT_READ:   push_cmd.kind = CMD_READ;
			ACT_SCROLL: push_cmd.kind = CMD_SCROLL;
			default:    push_cmd.kind = CMD_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_GROUND;
			p1_q   <= '0;
			p2_q   <= '0;
			slot_q <= '0;
		end else if (push) begin
			mode_q <= mode_d;
			p1_q   <= p1_d;
			p2_q   <= p2_d;
			slot_q <= slot_d;
		end
	end
endmodule
`default_nettype wire

// File: src/tts_queue.sv
// ---------------------------------------------------------------------------
// tts_queue
// Two-entry command queue between the parser front and the screen back.
// ---------------------------------------------------------------------------
`default_nettype none
module tts_queue import tts_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire cmd_t  push_cmd,
	output logic       full,
	input  wire logic  pop,
	output cmd_t       head,
	output logic       not_empty
);
	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	cmd_t                  mem_q [DEPTH];
	logic [PTR_W-1:0]      wr_q, rd_q;
	logic [PTR_W:0]        cnt_q;

	assign full      = cnt_q == (PTR_W+1)'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PTR_W'(1);
			if (pop) rd_q <= rd_q + PTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + (PTR_W+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (PTR_W+1)'(1);
		end
	end
endmodule
`default_nettype wire

// File: src/tts_back.sv
// ---------------------------------------------------------------------------
// tts_back
// Executes commands against the screen and history memories, handles
// register writes and holds the result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tts_back import tts_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	input  wire cmd_t  q_cmd,
	output logic       q_pop,
	tts_result_if.source result,
	tts_cfg_if.sink      cfg
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_BLANK,
		S_COPY,
		S_PUT,
		S_RADDR,
		S_RDATA,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		R_IDLE,
		R_DONE,
		R_PUT
	} ret_t;

	state_t              state_q;
	ret_t                ret_q;
	logic [RROWS_W-1:0]  rows_q;
	logic [RCOLS_W-1:0]  cols_q;
	logic [ROW_W-1:0]    base_q;
	logic [HIST_W-1:0]   head_q;
	logic [VIEW_W-1:0]   count_q, view_q;
	logic [ROW_W-1:0]    crow_q;
	logic [CCOL_W-1:0]   ccol_q;
	logic [RROWS_W-1:0]  brow_q, brow_end_q;
	logic [CCOL_W-1:0]   bcol_q, bcol_end_q, bcol_next_q;
	logic [CCOL_W-1:0]   copy_k_q;
	logic [ROW_W-1:0]    copy_src_q;
	logic [HIST_W-1:0]   copy_slot_q;
	logic [VIEW_W-1:0]   rd_idx_q;
	logic [VCOL_W-1:0]   rd_col_q;
	logic                rd_hist_q;
	logic [BYTE_W-1:0]   put_ch_q, cell_q;
	logic                changed_q;

	logic                res_valid_q;
	logic [BYTE_W-1:0]   res_cell_q;
	logic [ROW_W-1:0]    res_row_q;
	logic [CCOL_W-1:0]   res_col_q;
	logic [VIEW_W-1:0]   res_view_q, res_count_q;
	logic                res_changed_q;

	logic [RROWS_W-1:0]  er, new_rows;
	logic [RCOLS_W-1:0]  ec, new_cols;
	logic                lf_scroll, wrap;
	logic [8:0]          tab_sum;
	logic [CCOL_W-1:0]   tab_col;
	logic [PARAM_W-1:0]  n16, h_r, h_c;
	logic [ROW_W-1:0]    h_row, a_row, b_row;
	logic [CCOL_W-1:0]   h_col, c_col, d_col, k1_end;
	logic [16:0]         b_sum, c_sum;
	logic signed [10:0]  sc_sum;
	logic [VIEW_W-1:0]   sc_next;
	logic                rd_out;
	logic [VIEW_W-1:0]   rd_idx;
	logic [HIST_W-1:0]   slot;
	logic [VIEW_W-1:0]   count_new, view_new;
	logic                cfg_take;

	logic                      scr_we;
	logic [ROW_W+COL_W-1:0]    scr_waddr, scr_raddr;
	logic [BYTE_W-1:0]         scr_wdata, scr_rdata;
	logic                      hist_we;
	logic [HIST_W+COL_W-1:0]   hist_waddr, hist_raddr;
	logic [BYTE_W-1:0]         hist_rdata;

	assign er        = eff_rows(rows_q);
	assign ec        = eff_cols(cols_q);
	assign new_rows  = eff_rows(cfg.data[RROWS_W-1:0]);
	assign new_cols  = eff_cols(cfg.data);
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign cfg.ready = (state_q == S_IDLE) && !q_valid;
	assign cfg_take  = cfg.valid && cfg.ready;

	always_comb begin
		lf_scroll = ({1'b0, crow_q} + RROWS_W'(1)) >= er;
		wrap      = ccol_q >= ec;
		tab_sum   = ({1'b0, ccol_q} + 9'd8) & ~9'd7;
		tab_col   = (tab_sum >= {1'b0, ec}) ? ec - CCOL_W'(1) : tab_sum[CCOL_W-1:0];
		n16       = (q_cmd.p1 != '0) ? q_cmd.p1 : PARAM_W'(1);
		h_r       = (q_cmd.p1 != '0) ? q_cmd.p1 - PARAM_W'(1) : '0;
		h_c       = (q_cmd.p2 != '0) ? q_cmd.p2 - PARAM_W'(1) : '0;
		h_row     = (h_r >= PARAM_W'(er)) ? ROW_W'(er - RROWS_W'(1)) : h_r[ROW_W-1:0];
		h_col     = (h_c >= PARAM_W'(ec)) ? ec - CCOL_W'(1) : h_c[CCOL_W-1:0];
		a_row     = (n16 >= PARAM_W'(crow_q)) ? '0 : crow_q - n16[ROW_W-1:0];
		b_sum     = 17'(crow_q) + 17'(n16);
		b_row     = (b_sum >= 17'(er)) ? ROW_W'(er - RROWS_W'(1)) : b_sum[ROW_W-1:0];
		c_sum     = 17'(ccol_q) + 17'(n16);
		c_col     = (c_sum >= 17'(ec)) ? ec - CCOL_W'(1) : c_sum[CCOL_W-1:0];
		d_col     = (n16 >= PARAM_W'(ccol_q)) ? '0 : ccol_q - n16[CCOL_W-1:0];
		k1_end    = ((ccol_q < ec) ? ccol_q : ec - CCOL_W'(1)) + CCOL_W'(1);
		sc_sum    = $signed({2'b00, view_q}) + 11'(q_cmd.delta);
		if (sc_sum < 0) sc_next = '0;
		else if (sc_sum > $signed({2'b00, count_q})) sc_next = count_q;
		else sc_next = sc_sum[VIEW_W-1:0];
		rd_out    = ({1'b0, q_cmd.vrow} >= er) || ({1'b0, q_cmd.vcol} >= ec);
		rd_idx    = count_q - view_q + VIEW_W'(q_cmd.vrow);
		slot      = count_q[HIST_W] ? head_q : head_q + count_q[HIST_W-1:0];
		count_new = count_q[HIST_W] ? count_q : count_q + VIEW_W'(1);
		view_new  = view_q;
		if (view_q != '0 && view_q < count_new) view_new = view_q + VIEW_W'(1);
		else if (view_q > count_new) view_new = count_new;
	end

	always_comb begin
		scr_we     = (state_q == S_PUT) || ((state_q == S_BLANK) && (bcol_q < bcol_end_q));
		scr_wdata  = (state_q == S_PUT) ? put_ch_q : CH_BLANK;
		scr_waddr  = (state_q == S_PUT)
			? {ROW_W'(base_q + crow_q), ccol_q[COL_W-1:0]}
			: {ROW_W'(base_q + brow_q[ROW_W-1:0]), bcol_q[COL_W-1:0]};
		scr_raddr  = (state_q == S_COPY)
			? {copy_src_q, copy_k_q[COL_W-1:0]}
			: {ROW_W'(base_q + ROW_W'(rd_idx_q - count_q)), rd_col_q};
		hist_we    = (state_q == S_COPY) && (copy_k_q != '0);
		hist_waddr = {copy_slot_q, COL_W'(copy_k_q - CCOL_W'(1))};
		hist_raddr = {HIST_W'(head_q + rd_idx_q[HIST_W-1:0]), rd_col_q};
	end

	tts_ram #(.WIDTH(BYTE_W), .DEPTH(SCR_DEPTH)) u_screen (
		.clk   (clk),
		.we    (scr_we),
		.waddr (scr_waddr),
		.wdata (scr_wdata),
		.raddr (scr_raddr),
		.rdata (scr_rdata)
	);

	tts_ram #(.WIDTH(BYTE_W), .DEPTH(HIST_DEPTH)) u_history (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (scr_rdata),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_BLANK;
			ret_q         <= R_IDLE;
			rows_q        <= RROWS_W'(24);
			cols_q        <= RCOLS_W'(80);
			base_q        <= '0;
			head_q        <= '0;
			count_q       <= '0;
			view_q        <= '0;
			crow_q        <= '0;
			ccol_q        <= '0;
			brow_q        <= '0;
			brow_end_q    <= RROWS_W'(MAX_ROWS);
			bcol_q        <= '0;
			bcol_end_q    <= CCOL_W'(MAX_COLS);
			bcol_next_q   <= '0;
			copy_k_q      <= '0;
			copy_src_q    <= '0;
			copy_slot_q   <= '0;
			rd_idx_q      <= '0;
			rd_col_q      <= '0;
			rd_hist_q     <= 1'b0;
			put_ch_q      <= '0;
			cell_q        <= CH_BLANK;
			changed_q     <= 1'b0;
			res_valid_q   <= 1'b0;
			res_cell_q    <= '0;
			res_row_q     <= '0;
			res_col_q     <= '0;
			res_view_q    <= '0;
			res_count_q   <= '0;
			res_changed_q <= 1'b0;
		end else begin
			if (res_valid_q && result.ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					cell_q    <= CH_BLANK;
					changed_q <= 1'b0;
					ret_q     <= R_DONE;
					if (q_valid) begin
						state_q <= S_DONE;
						unique case (q_cmd.kind)
							CMD_PRINT, CMD_LF: begin
								put_ch_q <= q_cmd.ch;
								if (q_cmd.kind == CMD_PRINT) begin
									state_q <= S_PUT;
									ret_q   <= R_PUT;
									if (wrap) ccol_q <= '0;
								end
								if (q_cmd.kind == CMD_LF || wrap) begin
									if (lf_scroll) begin
										crow_q      <= ROW_W'(er - RROWS_W'(1));
										copy_src_q  <= base_q;
										base_q      <= base_q + ROW_W'(1);
										copy_slot_q <= slot;
										copy_k_q    <= '0;
										if (count_q[HIST_W]) head_q <= head_q + HIST_W'(1);
										count_q     <= count_new;
										view_q      <= view_new;
										state_q     <= S_COPY;
									end else begin
										crow_q <= crow_q + ROW_W'(1);
									end
								end
							end
							CMD_CR: ccol_q <= '0;
							CMD_BS: if (ccol_q != '0) ccol_q <= ccol_q - CCOL_W'(1);
							CMD_TAB: ccol_q <= tab_col;
							CMD_CSI: begin
								bcol_next_q <= '0;
								bcol_end_q  <= ec;
								brow_q      <= RROWS_W'(crow_q);
								brow_end_q  <= RROWS_W'(crow_q) + RROWS_W'(1);
								bcol_q      <= ccol_q;
								priority case (q_cmd.ch)
									FIN_H, FIN_F: begin
										crow_q <= h_row;
										ccol_q <= h_col;
									end
									FIN_A: crow_q <= a_row;
									FIN_B: crow_q <= b_row;
									FIN_C: ccol_q <= c_col;
									FIN_D: ccol_q <= d_col;
									FIN_J: begin
										if (q_cmd.p1 == PARAM_W'(0)) begin
											brow_end_q <= er;
											state_q    <= S_BLANK;
										end else if (q_cmd.p1 == PARAM_W'(2)
											|| q_cmd.p1 == PARAM_W'(3)) begin
											base_q     <= '0;
											head_q     <= '0;
											count_q    <= '0;
											view_q     <= '0;
											crow_q     <= '0;
											ccol_q     <= '0;
											brow_q     <= '0;
											brow_end_q <= RROWS_W'(MAX_ROWS);
											bcol_q     <= '0;
											bcol_end_q <= CCOL_W'(MAX_COLS);
											state_q    <= S_BLANK;
										end
									end
									FIN_K: begin
										if (q_cmd.p1 == PARAM_W'(0)) begin
											state_q <= S_BLANK;
										end else if (q_cmd.p1 == PARAM_W'(1)) begin
											bcol_q     <= '0;
											bcol_end_q <= k1_end;
											state_q    <= S_BLANK;
										end else if (q_cmd.p1 == PARAM_W'(2)) begin
											bcol_q  <= '0;
											state_q <= S_BLANK;
										end
									end
									default: state_q <= S_DONE;
								endcase
							end
							CMD_READ: begin
								rd_idx_q <= rd_idx;
								rd_col_q <= q_cmd.vcol;
								if (!rd_out) state_q <= S_RADDR;
							end
							CMD_SCROLL: begin
								view_q    <= sc_next;
								changed_q <= sc_next != view_q;
							end
							default: state_q <= S_DONE;
						endcase
					end else if (cfg_take) begin
						ret_q       <= R_IDLE;
						bcol_q      <= '0;
						bcol_next_q <= '0;
						bcol_end_q  <= CCOL_W'(MAX_COLS);
						brow_q      <= '0;
						brow_end_q  <= RROWS_W'(MAX_ROWS);
						if (cfg.index == REG_ROWS) begin
							rows_q <= cfg.data[RROWS_W-1:0];
							if (new_rows > er) begin
								brow_q     <= er;
								brow_end_q <= new_rows;
								state_q    <= S_BLANK;
							end
							if ({1'b0, crow_q} >= new_rows) begin
								crow_q <= ROW_W'(new_rows - RROWS_W'(1));
							end
						end else if (cfg.index == REG_COLS) begin
							cols_q <= cfg.data;
							if (new_cols > ec) begin
								bcol_q      <= ec;
								bcol_next_q <= ec;
								bcol_end_q  <= new_cols;
								state_q     <= S_BLANK;
							end
							if (ccol_q > new_cols) ccol_q <= new_cols - CCOL_W'(1);
						end
					end
				end
				S_COPY: begin
					copy_k_q <= copy_k_q + CCOL_W'(1);
					if (copy_k_q == CCOL_W'(MAX_COLS)) begin
						brow_q      <= er - RROWS_W'(1);
						brow_end_q  <= er;
						bcol_q      <= '0;
						bcol_next_q <= '0;
						bcol_end_q  <= CCOL_W'(MAX_COLS);
						state_q     <= S_BLANK;
					end
				end
				S_BLANK: begin
					if ({1'b0, bcol_q} + 9'd1 < {1'b0, bcol_end_q}) begin
						bcol_q <= bcol_q + CCOL_W'(1);
					end else if ({1'b0, brow_q} + 8'd1 < {1'b0, brow_end_q}) begin
						brow_q <= brow_q + RROWS_W'(1);
						bcol_q <= bcol_next_q;
					end else begin
						unique case (ret_q)
							R_IDLE:  state_q <= S_IDLE;
							R_PUT:   state_q <= S_PUT;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_PUT: begin
					ccol_q  <= ccol_q + CCOL_W'(1);
					state_q <= S_DONE;
				end
				S_RADDR: begin
					rd_hist_q <= rd_idx_q < count_q;
					state_q   <= S_RDATA;
				end
				S_RDATA: begin
					cell_q  <= rd_hist_q ? hist_rdata : scr_rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || result.ready) begin
						res_valid_q   <= 1'b1;
						res_cell_q    <= cell_q;
						res_row_q     <= crow_q;
						res_col_q     <= ccol_q;
						res_view_q    <= view_q;
						res_count_q   <= count_q;
						res_changed_q <= changed_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid              = res_valid_q;
	assign result.cell_char          = res_cell_q;
	assign result.cursor_row         = res_row_q;
	assign result.cursor_col         = res_col_q;
	assign result.view_back          = res_view_q;
	assign result.history_lines_held = res_count_q;
	assign result.view_changed       = res_changed_q;

	`TTS_ASSERT_ALWAYS(a_view_within_history, clk, arst_n, view_q <= count_q)
	`TTS_ASSERT_IMPLY(a_row_in_screen, clk, arst_n, state_q == S_IDLE, {1'b0, crow_q} < er)
	`TTS_ASSERT_IMPLY(a_col_in_screen, clk, arst_n, state_q == S_IDLE, ccol_q <= ec)
endmodule
`default_nettype wire

// File: src/text_terminal_screen_engine_top.sv
// ---------------------------------------------------------------------------
// text_terminal_screen_engine_top
// Terminal screen engine: escape parser front, command queue, screen and
// scrollback back end.
// ---------------------------------------------------------------------------
// channel  dir  word
// item     in   action, data_byte, view_row, view_col, scroll_delta
// result   out  cell_char, cursor_row, cursor_col, view_back,
//               history_lines_held, view_changed
// cfg      in   index, data (0 screen_rows, 1 screen_cols)
//
// Every accepted word returns one result word; printed bytes pass through a
// put state, and in-range view reads through address and data states, first.
// A scroll copies a row into history and blanks a row.
// Line clears walk one cell a cycle; full clear and reset sweep the whole screen.
// A 2-word queue and the result register keep input flowing during stalls.
// ---------------------------------------------------------------------------
`default_nettype none
module text_terminal_screen_engine_top import tts_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tts_item_if.sink     item,
	tts_result_if.source result,
	tts_cfg_if.sink      cfg
);
	logic  push, full, pop, not_empty;
	cmd_t  push_cmd, head;

	tts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	tts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty)
	);

	tts_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (not_empty),
		.q_cmd   (head),
		.q_pop   (pop),
		.result  (result),
		.cfg     (cfg)
	);
endmodule
`default_nettype wire

// File: tb/sv/text_terminal_screen_engine_top_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// text_terminal_screen_engine_top_test
// Self-checking bench for the terminal screen engine. A queue-fed driver
// offers output bytes, view reads and view scrolls with random gaps. A
// word-level screen predictor works out the status word for each accepted
// word, and a monitor compares every returned word field by field. Phases
// walk through several screen sizes, including the clamped extremes, and
// one phase overflows the scrollback ring.
// ---------------------------------------------------------------------------
module text_terminal_screen_engine_top_test;
	import tts_pkg::*;

	typedef enum logic [2:0] {PM_GROUND, PM_ESC, PM_CSI, PM_OSC, PM_OSC_ESC} parse_mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 4'd9;
	localparam logic [7:0]           FIN_UNKNOWN = 8'h7a;

	typedef struct {
		logic [ACTION_W-1:0]       action;
		logic [BYTE_W-1:0]         data_byte;
		logic [VROW_W-1:0]         view_row;
		logic [VCOL_W-1:0]         view_col;
		logic signed [DELTA_W-1:0] scroll_delta;
	} term_word_t;

	typedef struct {
		logic [BYTE_W-1:0] ch;
		logic [ROW_W-1:0]  crow;
		logic [CCOL_W-1:0] ccol;
		logic [VIEW_W-1:0] vback;
		logic [VIEW_W-1:0] held;
		logic              chg;
	} status_t;

	logic clk;
	logic arst_n;

	tts_item_if   item();
	tts_result_if result();
	tts_cfg_if    cfg();

	text_terminal_screen_engine_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	term_word_t pending_words[$];
	status_t    status_due[$];
	status_t    status_got;
	int         errors = 0;
	int         results_seen = 0;
	int         cycle_cnt = 0;
	int         hold_left = 0;
	logic       hold_done = 1'b0;
	logic       calm;

	// screen predictor state
	logic [7:0]  scr_m [SCR_DEPTH];
	logic [7:0]  hist_m [HIST_DEPTH];
	int unsigned hist_head, hist_cnt, view_off, row_base, cur_row, cur_col;
	int unsigned arg1, arg2, arg_slot;
	parse_mode_t pmode;
	logic [RROWS_W-1:0] rows_raw;
	logic [RCOLS_W-1:0] cols_raw;

	function automatic int unsigned rows_used();
		if (rows_raw == 0) return 1;
		return (rows_raw > MAX_ROWS) ? MAX_ROWS : rows_raw;
	endfunction

	function automatic int unsigned cols_used();
		if (cols_raw == 0) return 1;
		return (cols_raw > MAX_COLS) ? MAX_COLS : cols_raw;
	endfunction

	function automatic int unsigned phys_row(int unsigned r);
		return (row_base + r % MAX_ROWS) % MAX_ROWS;
	endfunction

	function automatic void blank_cells(int unsigned r, int unsigned from, int unsigned to);
		int unsigned p;
		p = phys_row(r);
		if (to > MAX_COLS) to = MAX_COLS;
		for (int unsigned i = from; i < to; i++) scr_m[p * MAX_COLS + i] = CH_BLANK;
	endfunction

	function automatic void clear_screen();
		foreach (scr_m[i]) scr_m[i] = CH_BLANK;
		row_base = 0;
		hist_head = 0;
		hist_cnt = 0;
		view_off = 0;
		cur_row = 0;
		cur_col = 0;
	endfunction

	function automatic void scroll_screen();
		int unsigned slot, src;
		src = phys_row(0);
		if (hist_cnt >= HIST_LINES) begin
			slot = hist_head;
			hist_head = (hist_head + 1) % HIST_LINES;
		end else begin
			slot = (hist_head + hist_cnt) % HIST_LINES;
			hist_cnt++;
		end
		for (int i = 0; i < MAX_COLS; i++)
			hist_m[slot * MAX_COLS + i] = scr_m[src * MAX_COLS + i];
		if (view_off > 0 && view_off < hist_cnt) view_off++;
		if (view_off > hist_cnt) view_off = hist_cnt;
		row_base = (row_base + 1) % MAX_ROWS;
		blank_cells(rows_used() - 1, 0, MAX_COLS);
	endfunction

	function automatic void new_line();
		cur_row++;
		if (cur_row >= rows_used()) begin
			scroll_screen();
			cur_row = rows_used() - 1;
		end
	endfunction

	function automatic void print_byte(logic [7:0] c);
		if (c == CH_LF) begin
			new_line();
		end else if (c == CH_CR) begin
			cur_col = 0;
		end else if (c == CH_BS || c == CH_DEL) begin
			if (cur_col > 0) cur_col--;
		end else if (c == CH_TAB) begin
			cur_col = (cur_col + 8) & ~32'd7;
			if (cur_col >= cols_used()) cur_col = cols_used() - 1;
		end else if (c >= CH_BLANK) begin
			if (cur_col >= cols_used()) begin
				cur_col = 0;
				new_line();
			end
			scr_m[phys_row(cur_row) * MAX_COLS + cur_col % MAX_COLS] = c;
			cur_col++;
		end
	endfunction

	function automatic void run_final(logic [7:0] c);
		int unsigned n, rows, cols, last;
		rows = rows_used();
		cols = cols_used();
		n = (arg1 > 0) ? arg1 : 1;
		case (c)
			FIN_H, FIN_F: begin
				cur_row = (arg1 > 0) ? arg1 - 1 : 0;
				cur_col = (arg2 > 0) ? arg2 - 1 : 0;
				if (cur_row >= rows) cur_row = rows - 1;
				if (cur_col >= cols) cur_col = cols - 1;
			end
			FIN_A: cur_row = (n >= cur_row) ? 0 : cur_row - n;
			FIN_B: begin
				cur_row += n;
				if (cur_row >= rows) cur_row = rows - 1;
			end
			FIN_C: begin
				cur_col += n;
				if (cur_col >= cols) cur_col = cols - 1;
			end
			FIN_D: cur_col = (n >= cur_col) ? 0 : cur_col - n;
			FIN_J: begin
				if (arg1 == 0) begin
					blank_cells(cur_row, cur_col, cols);
					for (int unsigned r = cur_row + 1; r < rows; r++) blank_cells(r, 0, cols);
				end else if (arg1 == 2 || arg1 == 3) begin
					clear_screen();
				end
			end
			FIN_K: begin
				if (arg1 == 0) begin
					blank_cells(cur_row, cur_col, cols);
				end else if (arg1 == 1) begin
					last = (cur_col < cols) ? cur_col : cols - 1;
					blank_cells(cur_row, 0, last + 1);
				end else if (arg1 == 2) begin
					blank_cells(cur_row, 0, cols);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void feed(logic [7:0] c);
		case (pmode)
			PM_ESC: begin
				if (c == CH_LBRACK) begin
					pmode = PM_CSI;
					arg1 = 0;
					arg2 = 0;
					arg_slot = 0;
				end else if (c == CH_RBRACK) begin
					pmode = PM_OSC;
				end else begin
					pmode = PM_GROUND;
				end
			end
			PM_CSI: begin
				if (c >= CH_0 && c <= CH_9) begin
					if (arg_slot == 0) begin
						arg1 = arg1 * 10 + (c - CH_0);
						if (arg1 > 65535) arg1 = 65535;
					end else if (arg_slot == 1) begin
						arg2 = arg2 * 10 + (c - CH_0);
						if (arg2 > 65535) arg2 = 65535;
					end
				end else if (c == CH_SEMI) begin
					if (arg_slot < 7) arg_slot++;
				end else begin
					pmode = PM_GROUND;
					run_final(c);
				end
			end
			PM_OSC: begin
				if (c == CH_BEL) pmode = PM_GROUND;
				else if (c == CH_ESC) pmode = PM_OSC_ESC;
			end
			PM_OSC_ESC: begin
				if (c == CH_BSLASH || c == CH_BEL) pmode = PM_GROUND;
				else if (c != CH_ESC) pmode = PM_OSC;
			end
			default: begin
				if (c == CH_ESC) pmode = PM_ESC;
				else print_byte(c);
			end
		endcase
	endfunction

	function automatic logic [7:0] view_char(int unsigned r, int unsigned c);
		int unsigned idx;
		if (r >= rows_used() || c >= cols_used()) return CH_BLANK;
		idx = hist_cnt - view_off + r;
		if (idx < hist_cnt)
			return hist_m[((hist_head + idx) % HIST_LINES) * MAX_COLS + c];
		return scr_m[phys_row(idx - hist_cnt) * MAX_COLS + c];
	endfunction

	function automatic status_t apply_word(term_word_t w);
		status_t s;
		int      nxt;
		s.ch = CH_BLANK;
		s.chg = 1'b0;
		case (w.action)
			ACT_BYTE: feed(w.data_byte);
			ACT_READ: s.ch = view_char(w.view_row, w.view_col);
			ACT_SCROLL: begin
				nxt = int'(view_off) + int'(w.scroll_delta);
				if (nxt < 0) nxt = 0;
				if (nxt > int'(hist_cnt)) nxt = hist_cnt;
				if (nxt != int'(view_off)) begin
					view_off = nxt;
					s.chg = 1'b1;
				end
			end
			default: ;
		endcase
		s.crow = cur_row[ROW_W-1:0];
		s.ccol = cur_col[CCOL_W-1:0];
		s.vback = view_off[VIEW_W-1:0];
		s.held = hist_cnt[VIEW_W-1:0];
		return s;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		int unsigned old, now;
		if (idx == REG_ROWS) begin
			old = rows_used();
			rows_raw = val[RROWS_W-1:0];
			now = rows_used();
			for (int unsigned r = old; r < now; r++) blank_cells(r, 0, MAX_COLS);
			if (cur_row >= now) cur_row = now - 1;
		end else if (idx == REG_COLS) begin
			old = cols_used();
			cols_raw = val;
			now = cols_used();
			if (now > old)
				for (int unsigned r = 0; r < MAX_ROWS; r++) blank_cells(r, old, now);
			if (cur_col > now) cur_col = now - 1;
		end
	endfunction

	// stimulus builders
	function automatic void push_char(logic [7:0] c);
		term_word_t w;
		w.action = ACT_BYTE;
		w.data_byte = c;
		w.view_row = VROW_W'($urandom);
		w.view_col = VCOL_W'($urandom);
		w.scroll_delta = DELTA_W'($urandom);
		pending_words.push_back(w);
	endfunction

	function automatic void push_read(int unsigned r, int unsigned c);
		term_word_t w;
		w.action = ACT_READ;
		w.data_byte = BYTE_W'($urandom);
		w.view_row = VROW_W'(r);
		w.view_col = VCOL_W'(c);
		w.scroll_delta = DELTA_W'($urandom);
		pending_words.push_back(w);
	endfunction

	function automatic void push_scroll(int d);
		term_word_t w;
		w.action = ACT_SCROLL;
		w.data_byte = BYTE_W'($urandom);
		w.view_row = VROW_W'($urandom);
		w.view_col = VCOL_W'($urandom);
		w.scroll_delta = DELTA_W'(d);
		pending_words.push_back(w);
	endfunction

	function automatic void push_num(int unsigned v);
		int unsigned digits[$];
		do begin
			digits.push_front(v % 10);
			v = v / 10;
		end while (v > 0);
		foreach (digits[i]) push_char(8'(CH_0 + digits[i]));
	endfunction

	// negative argument: omit it
	function automatic void push_csi(int p1, int p2, logic [7:0] fin);
		push_char(CH_ESC);
		push_char(CH_LBRACK);
		if (p1 >= 0) push_num(p1);
		if (p2 >= 0) begin
			push_char(CH_SEMI);
			push_num(p2);
		end
		push_char(fin);
	endfunction

	function automatic int rand_arg();
		int unsigned k;
		k = $urandom_range(0, 99);
		if (k < 55) return $urandom_range(0, 70);
		if (k < 75) return -1;
		if (k < 88) return $urandom_range(0, 300);
		return $urandom_range(65530, 200000);
	endfunction

	function automatic void rand_chunk(int lf_pct);
		int unsigned k, n;
		logic [7:0]  fins[9];
		fins = '{FIN_H, FIN_F, FIN_A, FIN_B, FIN_C, FIN_D, FIN_J, FIN_K, FIN_UNKNOWN};
		if ($urandom_range(0, 99) < lf_pct) begin
			push_char(CH_LF);
			return;
		end
		k = $urandom_range(0, 99);
		if (k < 30) begin
			push_char(8'($urandom_range(32, 255)));
		end else if (k < 38) begin
			push_char(CH_LF);
		end else if (k < 42) begin
			push_char(CH_CR);
		end else if (k < 46) begin
			push_char(($urandom_range(0, 1) == 0) ? CH_BS : CH_DEL);
		end else if (k < 49) begin
			push_char(CH_TAB);
		end else if (k < 52) begin
			push_char(8'($urandom_range(0, 255)));
		end else if (k < 63) begin
			n = $urandom_range(0, 8);
			if (fins[n] == FIN_J) begin
				push_csi(($urandom_range(0, 15) == 0) ? $urandom_range(2, 3)
					: (($urandom_range(0, 3) == 0) ? 5 : 0), -1, FIN_J);
			end else if (fins[n] == FIN_K) begin
				push_csi($urandom_range(0, 3), -1, FIN_K);
			end else if ($urandom_range(0, 9) == 0) begin
				push_char(CH_ESC);
				push_char(CH_LBRACK);
				push_num($urandom_range(1, 9));
				repeat ($urandom_range(2, 10)) push_char(CH_SEMI);
				push_num($urandom_range(0, 99));
				push_char(fins[n]);
			end else begin
				push_csi(rand_arg(), rand_arg(), fins[n]);
			end
		end else if (k < 66) begin
			push_char(CH_ESC);
			push_char(CH_RBRACK);
			repeat ($urandom_range(0, 6)) push_char(8'($urandom_range(32, 126)));
			if ($urandom_range(0, 2) == 0) begin
				push_char(CH_ESC);
				push_char(CH_ESC);
				push_char(8'($urandom_range(32, 91)));
			end
			if ($urandom_range(0, 1) == 0) begin
				push_char(CH_BEL);
			end else begin
				push_char(CH_ESC);
				push_char(CH_BSLASH);
			end
		end else if (k < 68) begin
			push_char(CH_ESC);
			push_char(8'($urandom_range(0, 255)));
		end else if (k < 86) begin
			if ($urandom_range(0, 3) != 0)
				push_read($urandom_range(0, rows_used() - 1), $urandom_range(0, cols_used() - 1));
			else
				push_read($urandom_range(0, 63), $urandom_range(0, 127));
		end else begin
			k = $urandom_range(0, 9);
			if (k < 2) push_scroll(($urandom_range(0, 1) == 0) ? -256 : 256);
			else if (k < 6) push_scroll($urandom_range(0, 16) - 8);
			else push_scroll($urandom_range(0, 512) - 256);
		end
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		apply_reg(idx, val);
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || status_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic run_phase(input logic [7:0] rows, input logic [7:0] cols, input int n,
		input int lf_pct);
		write_reg(REG_ROWS, rows);
		write_reg(REG_COLS, cols);
		@(negedge clk);
		while (pending_words.size() < n) rand_chunk(lf_pct);
		drain();
	endtask

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	assign calm = (cycle_cnt % 20000) < 4000;

	// item driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item.valid <= 1'b0;
		end else begin
			if (item.valid && item.ready) begin
				status_due.push_back(apply_word(pending_words[0]));
				pending_words.pop_front();
			end
			if (!item.valid || item.ready) begin
				if (pending_words.size() > 0 && (calm || $urandom_range(0, 99) >= 38)) begin
					item.valid <= 1'b1;
					item.action <= pending_words[0].action;
					item.data_byte <= pending_words[0].data_byte;
					item.view_row <= pending_words[0].view_row;
					item.view_col <= pending_words[0].view_col;
					item.scroll_delta <= pending_words[0].scroll_delta;
				end else begin
					item.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= 30) begin
			hold_done <= 1'b1;
			hold_left <= 500;
		end
	end

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				results_seen <= results_seen + 1;
				if (status_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, expected none, actual cell %0d", $time,
						result.cell_char);
				end else begin
					status_got = status_due.pop_front();
					check_field("cell_char", status_got.ch, result.cell_char);
					check_field("cursor_row", status_got.crow, result.cursor_row);
					check_field("cursor_col", status_got.ccol, result.cursor_col);
					check_field("view_back", status_got.vback, result.view_back);
					check_field("history_lines_held", status_got.held, result.history_lines_held);
					check_field("view_changed", status_got.chg, result.view_changed);
				end
			end
			result.ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 38);
		end
	end

	initial begin
		#400_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.action = ACT_BYTE;
		item.data_byte = '0;
		item.view_row = '0;
		item.view_col = '0;
		item.scroll_delta = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_ROWS;
		cfg.data = '0;
		foreach (hist_m[i]) hist_m[i] = '0;
		clear_screen();
		pmode = PM_GROUND;
		arg1 = 0;
		arg2 = 0;
		arg_slot = 0;
		rows_raw = RROWS_W'(24);
		cols_raw = RCOLS_W'(80);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_ROWS, 8'd24);
		write_reg(REG_COLS, 8'd80);
		@(negedge clk);
		push_char(CH_BLANK);
		push_char(8'hff);
		push_char(8'h80);
		push_char(8'h00);
		push_char(8'h1f);
		push_char(CH_TAB);
		push_char(CH_BS);
		push_char(CH_DEL);
		push_char(CH_CR);
		push_char(CH_LF);
		push_csi(5, 10, FIN_H);
		push_csi(0, -1, FIN_A);
		push_csi(0, -1, FIN_B);
		push_csi(-1, -1, FIN_C);
		push_csi(99999, -1, FIN_D);
		push_csi(99, 999, FIN_F);
		push_csi(0, -1, FIN_K);
		push_csi(1, -1, FIN_K);
		push_csi(2, -1, FIN_K);
		push_csi(0, -1, FIN_J);
		push_csi(7, -1, FIN_UNKNOWN);
		push_char(CH_ESC);
		push_char(CH_ESC);
		push_char(CH_ESC);
		push_char(CH_RBRACK);
		push_char(8'h41);
		push_char(CH_BEL);
		push_char(CH_ESC);
		push_char(CH_RBRACK);
		push_char(CH_ESC);
		push_char(CH_BSLASH);
		push_read(0, 0);
		push_read(63, 127);
		push_scroll(256);
		push_scroll(-256);
		push_csi(2, -1, FIN_J);
		while (pending_words.size() < 85) rand_chunk(0);
		drain();

		run_phase(8'd64, 8'd128, 20, 0);
		run_phase(8'd1, 8'd1, 15, 10);
		write_reg(REG_UNUSED, 8'hff);
		run_phase(8'd0, 8'd0, 8, 0);
		run_phase(8'd127, 8'd255, 12, 0);

		// overflow the scrollback ring, then look around in it
		write_reg(REG_ROWS, 8'd4);
		write_reg(REG_COLS, 8'd16);
		@(negedge clk);
		repeat (262) begin
			push_char(CH_LF);
			if ($urandom_range(0, 15) == 0) push_char(8'($urandom_range(32, 126)));
			if ($urandom_range(0, 15) == 0) push_scroll($urandom_range(0, 40));
		end
		while (pending_words.size() < 290) rand_chunk(5);
		drain();
		run_phase(8'd24, 8'd80, 10, 0);

		if (errors == 0 && status_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
